/* rtl/core/mfd_pkg.sv */
// Shared types, codes and constants for the mono framebuffer draw engine.
`default_nettype none

package mfd_pkg;

    // Default screen size in pixels
    localparam int SCREEN_W_DEF = 128;
    localparam int SCREEN_H_DEF = 64;

    // Internal coordinate width: holds centre +/- radius plus span length
    localparam int CW = 20;
    typedef logic signed [CW-1:0] coord_t;

    // Stream widths
    localparam int IN_TDATA_W  = 120;
    localparam int IN_TUSER_W  = 4;
    localparam int OUT_TDATA_W = 8;

    // Command kinds
    localparam logic [3:0] KIND_CLEAR  = 4'd0;
    localparam logic [3:0] KIND_DOT    = 4'd1;
    localparam logic [3:0] KIND_HLINE  = 4'd2;
    localparam logic [3:0] KIND_VLINE  = 4'd3;
    localparam logic [3:0] KIND_LINE   = 4'd4;
    localparam logic [3:0] KIND_FRAME  = 4'd5;
    localparam logic [3:0] KIND_BOX    = 4'd6;
    localparam logic [3:0] KIND_CIRCLE = 4'd7;
    localparam logic [3:0] KIND_DISC   = 4'd8;
    localparam logic [3:0] KIND_READ   = 4'd9;

    // Pen codes
    localparam logic [1:0] PEN_WHITE = 2'd0;
    localparam logic [1:0] PEN_BLACK = 2'd1;
    localparam logic [1:0] PEN_XOR   = 2'd2;

    // Geometry datapath commands
    typedef enum logic [3:0] {
        GC_IDLE,
        GC_LOAD,
        GC_INIT_A,
        GC_INIT_B,
        GC_INIT_C,
        GC_DESC,
        GC_CLIP,
        GC_STEP,
        GC_NEXT
    } geom_op_t;

    // Framebuffer commands
    typedef enum logic [1:0] {
        FC_NONE,
        FC_VISIT,
        FC_READ,
        FC_CLEAR
    } fb_op_t;

    typedef struct packed {
        logic src_fin;
        logic span_more;
        logic rd_inb;
    } geom_sts_t;

    typedef struct packed {
        logic busy;
        logic rd_bit;
    } fb_sts_t;

    function automatic coord_t sext16(input logic [15:0] v);
        return coord_t'($signed(v));
    endfunction

    function automatic coord_t zext16(input logic [15:0] v);
        return $signed({{(CW-16){1'b0}}, v});
    endfunction

endpackage

`default_nettype wire

/* rtl/core/mfd_fb.sv */
// Framebuffer memory, one row per word, with read-modify-write and clear sweep.
`default_nettype none

module mfd_fb #(
    parameter int SCREEN_W = mfd_pkg::SCREEN_W_DEF,
    parameter int SCREEN_H = mfd_pkg::SCREEN_H_DEF
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire mfd_pkg::fb_op_t op,
    input  wire mfd_pkg::coord_t pt_x,
    input  wire mfd_pkg::coord_t pt_y,
    input  wire logic [1:0]     pen,
    output mfd_pkg::fb_sts_t    sts
);

    localparam int RB = $clog2(SCREEN_H);
    localparam int CB = $clog2(SCREEN_W);

    logic [SCREEN_W-1:0] mem [SCREEN_H];
    logic [SCREEN_W-1:0] row_data_reg;
    logic [SCREEN_W-1:0] row_mod;
    logic [SCREEN_W-1:0] wr_data;
    logic [RB-1:0]       row_reg;
    logic [RB-1:0]       clr_row_reg;
    logic [RB-1:0]       rd_addr;
    logic [RB-1:0]       wr_addr;
    logic [CB-1:0]       col_reg;
    logic [1:0]          pen_reg;
    logic                clr_busy_reg;
    logic                wr_pend_reg;
    logic                we;
    logic                bit_new;

    assign rd_addr = pt_y[RB-1:0];

    always_comb
    begin
        unique case (pen_reg)
            mfd_pkg::PEN_WHITE: bit_new = 1'b0;
            mfd_pkg::PEN_BLACK: bit_new = 1'b1;
            mfd_pkg::PEN_XOR:   bit_new = ~row_data_reg[col_reg];
            default:            bit_new = row_data_reg[col_reg];
        endcase
        row_mod          = row_data_reg;
        row_mod[col_reg] = bit_new;
    end

    assign we      = clr_busy_reg || wr_pend_reg;
    assign wr_addr = clr_busy_reg ? clr_row_reg : row_reg;
    assign wr_data = clr_busy_reg ? '0 : row_mod;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_busy_reg <= 1'b1;
            clr_row_reg  <= '0;
            wr_pend_reg  <= 1'b0;
        end
        else
        begin
            wr_pend_reg <= (op == mfd_pkg::FC_VISIT);
            if (op == mfd_pkg::FC_CLEAR)
            begin
                clr_busy_reg <= 1'b1;
                clr_row_reg  <= '0;
            end
            else if (clr_busy_reg)
            begin
                if (clr_row_reg == RB'(SCREEN_H - 1))
                    clr_busy_reg <= 1'b0;
                else
                    clr_row_reg <= clr_row_reg + 1'b1;
            end
        end
    end

    // Visit/read address capture
    always_ff @(posedge clk)
    begin
        if (op == mfd_pkg::FC_VISIT || op == mfd_pkg::FC_READ)
        begin
            row_reg <= pt_y[RB-1:0];
            col_reg <= pt_x[CB-1:0];
            pen_reg <= pen;
        end
    end

    always_ff @(posedge clk)
    begin
        if (we)
            mem[wr_addr] <= wr_data;
        row_data_reg <= mem[rd_addr];
    end

    assign sts.busy   = clr_busy_reg;
    assign sts.rd_bit = row_data_reg[col_reg];

endmodule

`default_nettype wire

/* rtl/core/mfd_geom.sv */
// Geometry datapath: shape walkers, span descriptors and span clipping.
`default_nettype none

module mfd_geom #(
    parameter int SCREEN_W = mfd_pkg::SCREEN_W_DEF,
    parameter int SCREEN_H = mfd_pkg::SCREEN_H_DEF
) (
    input  wire logic              clk,
    input  wire mfd_pkg::geom_op_t op,
    input  wire logic [3:0]        kind,
    input  wire logic [1:0]        pen,
    input  wire logic [15:0]       x_pos,
    input  wire logic [15:0]       y_pos,
    input  wire logic [15:0]       x_end,
    input  wire logic [15:0]       y_end,
    input  wire logic [15:0]       span_w,
    input  wire logic [15:0]       span_h,
    input  wire logic [15:0]       radius,
    output logic [1:0]             pen_q,
    output mfd_pkg::coord_t        pt_x,
    output mfd_pkg::coord_t        pt_y,
    output mfd_pkg::geom_sts_t     sts
);

    localparam mfd_pkg::coord_t LimW = mfd_pkg::coord_t'(SCREEN_W);
    localparam mfd_pkg::coord_t LimH = mfd_pkg::coord_t'(SCREEN_H);
    localparam mfd_pkg::coord_t One  = mfd_pkg::coord_t'(1);
    localparam mfd_pkg::coord_t Two  = mfd_pkg::coord_t'(2);
    localparam logic [3:0]      FrameSides = 4'd4;
    localparam logic [2:0]      OctLast    = 3'd7;

    // Latched command
    logic [3:0]      kind_reg;
    logic [1:0]      pen_reg;
    mfd_pkg::coord_t xp_reg, yp_reg, xe_reg, ye_reg, w_reg, h_reg, r_reg;

    // Walker state
    logic [3:0]      k_reg;
    logic            fin_reg;
    mfd_pkg::coord_t row_reg, row_end_reg;
    mfd_pkg::coord_t ldx_reg, ldy_reg, lax_reg, lay_reg, lbx_reg, lby_reg;
    mfd_pkg::coord_t lcx_reg, lcy_reg, err_reg;
    logic            steep_reg, step_up_reg;
    mfd_pkg::coord_t cf_reg, cddx_reg, cddy_reg, ca_reg, cb_reg;

    // Span
    logic            sp_vert_reg, sp_ok_reg;
    mfd_pkg::coord_t sp_fix_reg, sp_start_reg, sp_len_reg, sp_cur_reg, sp_end_reg;

    // Combinational helpers
    logic            d_vert;
    mfd_pkg::coord_t d_fix, d_start, d_len;
    mfd_pkg::coord_t u_v, v_v, yh;
    mfd_pkg::coord_t adx, ady;
    logic            steep, swap;
    mfd_pkg::coord_t err_m;
    logic            c_fpos;
    mfd_pkg::coord_t c_ddy_n, c_ddx_n, cf_n;
    mfd_pkg::coord_t lim, flim, c_end;
    logic            src_fin;

    assign yh = yp_reg + h_reg;

    // Bresenham set-up
    assign adx   = (ldx_reg < 0) ? -ldx_reg : ldx_reg;
    assign ady   = (ldy_reg < 0) ? -ldy_reg : ldy_reg;
    assign steep = ady > adx;
    assign swap  = lax_reg > lbx_reg;
    assign err_m = err_reg - ldy_reg;

    // Midpoint step
    assign c_fpos  = !cf_reg[mfd_pkg::CW-1];
    assign c_ddy_n = c_fpos ? cddy_reg + Two : cddy_reg;
    assign c_ddx_n = cddx_reg + Two;
    assign cf_n    = cf_reg + (c_fpos ? c_ddy_n : '0) + c_ddx_n;

    // Span clip
    assign lim   = sp_vert_reg ? LimH : LimW;
    assign flim  = sp_vert_reg ? LimW : LimH;
    assign c_end = sp_start_reg + sp_len_reg;

    // Next span descriptor
    always_comb
    begin
        u_v     = k_reg[0] ? cb_reg : ca_reg;
        v_v     = k_reg[0] ? ca_reg : cb_reg;
        d_vert  = 1'b0;
        d_fix   = yp_reg;
        d_start = xp_reg;
        d_len   = One;
        unique case (kind_reg)
            mfd_pkg::KIND_HLINE:
                d_len = w_reg;
            mfd_pkg::KIND_VLINE:
            begin
                d_vert  = 1'b1;
                d_fix   = xp_reg;
                d_start = yp_reg;
                d_len   = w_reg;
            end
            mfd_pkg::KIND_FRAME:
            begin
                unique case (k_reg[1:0])
                    2'd0:
                        d_len = w_reg;
                    2'd1:
                    begin
                        d_fix = yh - One;
                        d_len = w_reg;
                    end
                    2'd2:
                    begin
                        d_vert  = 1'b1;
                        d_fix   = xp_reg;
                        d_start = yp_reg;
                        d_len   = h_reg;
                    end
                    default:
                    begin
                        d_vert  = 1'b1;
                        d_fix   = xp_reg + w_reg - One;
                        d_start = yp_reg;
                        d_len   = h_reg;
                    end
                endcase
            end
            mfd_pkg::KIND_BOX:
            begin
                d_fix = row_reg;
                d_len = w_reg;
            end
            mfd_pkg::KIND_LINE:
            begin
                d_fix   = steep_reg ? lcx_reg : lcy_reg;
                d_start = steep_reg ? lcy_reg : lcx_reg;
            end
            mfd_pkg::KIND_CIRCLE, mfd_pkg::KIND_DISC:
            begin
                d_vert = 1'b1;
                d_fix  = k_reg[1] ? xp_reg - u_v : xp_reg + u_v;
                if (kind_reg == mfd_pkg::KIND_DISC)
                begin
                    d_start = k_reg[2] ? yp_reg : yp_reg - v_v;
                    d_len   = v_v + One;
                end
                else
                begin
                    d_start = k_reg[2] ? yp_reg + v_v : yp_reg - v_v;
                end
            end
            default: ;
        endcase
    end

    // Source exhausted
    always_comb
    begin
        unique case (kind_reg)
            mfd_pkg::KIND_DOT, mfd_pkg::KIND_HLINE, mfd_pkg::KIND_VLINE:
                src_fin = (k_reg != 4'd0);
            mfd_pkg::KIND_FRAME:
                src_fin = (w_reg == 0) || (h_reg == 0) || (k_reg == FrameSides);
            mfd_pkg::KIND_BOX:
                src_fin = (row_reg >= row_end_reg);
            mfd_pkg::KIND_LINE:
                src_fin = (lcx_reg > lbx_reg);
            mfd_pkg::KIND_CIRCLE, mfd_pkg::KIND_DISC:
                src_fin = fin_reg;
            default:
                src_fin = 1'b1;
        endcase
    end

    assign sts.src_fin   = src_fin;
    assign sts.span_more = sp_ok_reg && (sp_cur_reg < sp_end_reg);
    assign sts.rd_inb    = (xp_reg >= 0) && (xp_reg < LimW) && (yp_reg >= 0) && (yp_reg < LimH);

    always_comb
    begin
        if (kind_reg == mfd_pkg::KIND_READ)
        begin
            pt_x = xp_reg;
            pt_y = yp_reg;
        end
        else
        begin
            pt_x = sp_vert_reg ? sp_fix_reg : sp_cur_reg;
            pt_y = sp_vert_reg ? sp_cur_reg : sp_fix_reg;
        end
    end

    assign pen_q = pen_reg;

    always_ff @(posedge clk)
    begin
        unique case (op)
            mfd_pkg::GC_LOAD:
            begin
                kind_reg <= kind;
                pen_reg  <= pen;
                xp_reg   <= mfd_pkg::sext16(x_pos);
                yp_reg   <= mfd_pkg::sext16(y_pos);
                xe_reg   <= mfd_pkg::sext16(x_end);
                ye_reg   <= mfd_pkg::sext16(y_end);
                w_reg    <= mfd_pkg::zext16(span_w);
                h_reg    <= mfd_pkg::zext16(span_h);
                r_reg    <= mfd_pkg::zext16(radius);
            end
            mfd_pkg::GC_INIT_A:
            begin
                ldx_reg     <= xe_reg - xp_reg;
                ldy_reg     <= ye_reg - yp_reg;
                row_reg     <= (yp_reg < 0) ? '0 : yp_reg;
                row_end_reg <= (yh > LimH) ? LimH : yh;
                cf_reg      <= One - r_reg;
                cddx_reg    <= One;
                cddy_reg    <= '0 - (r_reg <<< 1);
                ca_reg      <= '0;
                cb_reg      <= r_reg;
                k_reg       <= '0;
                fin_reg     <= 1'b0;
            end
            mfd_pkg::GC_INIT_B:
            begin
                steep_reg <= steep;
                lax_reg   <= steep ? yp_reg : xp_reg;
                lay_reg   <= steep ? xp_reg : yp_reg;
                lbx_reg   <= steep ? ye_reg : xe_reg;
                lby_reg   <= steep ? xe_reg : ye_reg;
                ldx_reg   <= steep ? ady : adx;
                ldy_reg   <= steep ? adx : ady;
            end
            mfd_pkg::GC_INIT_C:
            begin
                lcx_reg     <= swap ? lbx_reg : lax_reg;
                lcy_reg     <= swap ? lby_reg : lay_reg;
                lbx_reg     <= swap ? lax_reg : lbx_reg;
                step_up_reg <= (swap ? lay_reg : lby_reg) > (swap ? lby_reg : lay_reg);
                err_reg     <= ldx_reg >>> 1;
            end
            mfd_pkg::GC_DESC:
            begin
                sp_vert_reg  <= d_vert;
                sp_fix_reg   <= d_fix;
                sp_start_reg <= d_start;
                sp_len_reg   <= d_len;
            end
            mfd_pkg::GC_CLIP:
            begin
                sp_ok_reg  <= (sp_fix_reg >= 0) && (sp_fix_reg < flim) && (sp_len_reg != 0);
                sp_cur_reg <= (sp_start_reg < 0) ? '0 : sp_start_reg;
                sp_end_reg <= (c_end > lim) ? lim : c_end;
            end
            mfd_pkg::GC_STEP:
                sp_cur_reg <= sp_cur_reg + One;
            mfd_pkg::GC_NEXT:
            begin
                unique case (kind_reg)
                    mfd_pkg::KIND_BOX:
                        row_reg <= row_reg + One;
                    mfd_pkg::KIND_LINE:
                    begin
                        lcx_reg <= lcx_reg + One;
                        if (err_m < 0)
                        begin
                            lcy_reg <= step_up_reg ? lcy_reg + One : lcy_reg - One;
                            err_reg <= err_m + ldx_reg;
                        end
                        else
                            err_reg <= err_m;
                    end
                    mfd_pkg::KIND_CIRCLE, mfd_pkg::KIND_DISC:
                    begin
                        if (k_reg[2:0] != OctLast)
                            k_reg <= k_reg + 4'd1;
                        else if (ca_reg < cb_reg)
                        begin
                            k_reg    <= '0;
                            ca_reg   <= ca_reg + One;
                            cb_reg   <= c_fpos ? cb_reg - One : cb_reg;
                            cddx_reg <= c_ddx_n;
                            cddy_reg <= c_ddy_n;
                            cf_reg   <= cf_n;
                        end
                        else
                            fin_reg <= 1'b1;
                    end
                    default:
                        k_reg <= k_reg + 4'd1;
                endcase
            end
            default: ;
        endcase
    end

endmodule

`default_nettype wire

/* rtl/core/mfd_ctrl.sv */
// Command sequencer: handshakes, span/visit loop and result register.
`default_nettype none

module mfd_ctrl (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire logic [3:0]         in_kind,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic                    out_value,
    output logic                    out_inb,
    output mfd_pkg::geom_op_t       g_op,
    input  wire mfd_pkg::geom_sts_t g_sts,
    output mfd_pkg::fb_op_t         f_op,
    input  wire mfd_pkg::fb_sts_t   f_sts
);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_INIT_A,
        ST_INIT_B,
        ST_INIT_C,
        ST_DESC,
        ST_CLIP,
        ST_PIX,
        ST_PWAIT,
        ST_CLR,
        ST_RD,
        ST_RDW,
        ST_FIN
    } state_t;

    state_t state_reg;
    logic   out_valid_reg, out_value_reg, out_inb_reg;
    logic   res_value_reg, res_inb_reg;
    logic   accept;

    assign in_ready  = (state_reg == ST_IDLE) && !f_sts.busy;
    assign accept    = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign out_value = out_value_reg;
    assign out_inb   = out_inb_reg;

    always_comb
    begin
        g_op = mfd_pkg::GC_IDLE;
        f_op = mfd_pkg::FC_NONE;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    g_op = mfd_pkg::GC_LOAD;
                    if (in_kind == mfd_pkg::KIND_CLEAR)
                        f_op = mfd_pkg::FC_CLEAR;
                end
            end
            ST_INIT_A: g_op = mfd_pkg::GC_INIT_A;
            ST_INIT_B: g_op = mfd_pkg::GC_INIT_B;
            ST_INIT_C: g_op = mfd_pkg::GC_INIT_C;
            ST_DESC:
                if (!g_sts.src_fin)
                    g_op = mfd_pkg::GC_DESC;
            ST_CLIP:   g_op = mfd_pkg::GC_CLIP;
            ST_PIX:
            begin
                if (g_sts.span_more)
                begin
                    g_op = mfd_pkg::GC_STEP;
                    f_op = mfd_pkg::FC_VISIT;
                end
                else
                    g_op = mfd_pkg::GC_NEXT;
            end
            ST_RD:
                if (g_sts.rd_inb)
                    f_op = mfd_pkg::FC_READ;
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            out_value_reg <= 1'b0;
            out_inb_reg   <= 1'b0;
            res_value_reg <= 1'b0;
            res_inb_reg   <= 1'b0;
        end
        else
        begin
            // result register: load from FIN when free, else drop once taken
            if (state_reg == ST_FIN && (!out_valid_reg || out_ready))
            begin
                out_valid_reg <= 1'b1;
                out_value_reg <= res_value_reg;
                out_inb_reg   <= res_inb_reg;
            end
            else if (out_valid_reg && out_ready)
                out_valid_reg <= 1'b0;
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        res_value_reg <= 1'b0;
                        res_inb_reg   <= 1'b0;
                        priority if (in_kind == mfd_pkg::KIND_CLEAR)
                            state_reg <= ST_CLR;
                        else if (in_kind == mfd_pkg::KIND_READ)
                            state_reg <= ST_RD;
                        else if (in_kind >= mfd_pkg::KIND_DOT && in_kind <= mfd_pkg::KIND_DISC)
                            state_reg <= ST_INIT_A;
                        else
                            state_reg <= ST_FIN;
                    end
                end
                ST_INIT_A: state_reg <= ST_INIT_B;
                ST_INIT_B: state_reg <= ST_INIT_C;
                ST_INIT_C: state_reg <= ST_DESC;
                ST_DESC:   state_reg <= g_sts.src_fin ? ST_FIN : ST_CLIP;
                ST_CLIP:   state_reg <= ST_PIX;
                ST_PIX:    state_reg <= g_sts.span_more ? ST_PWAIT : ST_DESC;
                ST_PWAIT:  state_reg <= ST_PIX;
                ST_CLR:
                    if (!f_sts.busy)
                        state_reg <= ST_FIN;
                ST_RD:     state_reg <= g_sts.rd_inb ? ST_RDW : ST_FIN;
                ST_RDW:
                begin
                    res_value_reg <= f_sts.rd_bit;
                    res_inb_reg   <= 1'b1;
                    state_reg     <= ST_FIN;
                end
                ST_FIN:
                begin
                    if (!out_valid_reg || out_ready)
                        state_reg <= ST_IDLE;
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

endmodule

`default_nettype wire

/* rtl/core/mono_framebuffer_draw_engine.sv */
// Top level of the mono framebuffer draw engine.
// Each pixel visit is a row read, then a write-back on the one-port-write RAM; each span or
//   point adds set-up (descriptor, then clip), and each command adds decode and result.
// Commands are accepted one at a time.
// Reset: asynchronous, active low; afterwards a clearing pass zeroes the frame store one row
//   per cycle with s_axis_tready held low.
`default_nettype none

module mono_framebuffer_draw_engine #(
    parameter int SCREEN_W = mfd_pkg::SCREEN_W_DEF,
    parameter int SCREEN_H = mfd_pkg::SCREEN_H_DEF
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    // Command channel
    input  wire logic                             s_axis_tvalid,
    output logic                                  s_axis_tready,
    // pen[1:0], x_pos[17:2], y_pos[33:18], x_end[49:34], y_end[65:50],
    // span_w[81:66], span_h[97:82], radius[113:98], zero padding[119:114]
    input  wire logic [mfd_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
    // kind[3:0]
    input  wire logic [mfd_pkg::IN_TUSER_W-1:0]   s_axis_tuser,
    // Result channel
    output logic                                  m_axis_tvalid,
    input  wire logic                             m_axis_tready,
    // read_value[0], read_in_bounds[1], zero padding[7:2]
    output logic [mfd_pkg::OUT_TDATA_W-1:0]       m_axis_tdata
);

    mfd_pkg::geom_op_t  g_op;
    mfd_pkg::geom_sts_t g_sts;
    mfd_pkg::fb_op_t    f_op;
    mfd_pkg::fb_sts_t   f_sts;
    mfd_pkg::coord_t    pt_x, pt_y;
    logic [1:0]         pen_q;
    logic               out_value, out_inb;

    // Sequencer: one transaction in, one transaction out
    mfd_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_kind   (s_axis_tuser),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_value (out_value),
        .out_inb   (out_inb),
        .g_op      (g_op),
        .g_sts     (g_sts),
        .f_op      (f_op),
        .f_sts     (f_sts)
    );

    // Shape walkers feed clipped on-screen points
    mfd_geom #(
        .SCREEN_W (SCREEN_W),
        .SCREEN_H (SCREEN_H)
    ) u_geom (
        .clk    (clk),
        .op     (g_op),
        .kind   (s_axis_tuser),
        .pen    (s_axis_tdata[1:0]),
        .x_pos  (s_axis_tdata[17:2]),
        .y_pos  (s_axis_tdata[33:18]),
        .x_end  (s_axis_tdata[49:34]),
        .y_end  (s_axis_tdata[65:50]),
        .span_w (s_axis_tdata[81:66]),
        .span_h (s_axis_tdata[97:82]),
        .radius (s_axis_tdata[113:98]),
        .pen_q  (pen_q),
        .pt_x   (pt_x),
        .pt_y   (pt_y),
        .sts    (g_sts)
    );

    // Frame store with per-pixel read-modify-write
    mfd_fb #(
        .SCREEN_W (SCREEN_W),
        .SCREEN_H (SCREEN_H)
    ) u_fb (
        .clk   (clk),
        .rst_n (rst_n),
        .op    (f_op),
        .pt_x  (pt_x),
        .pt_y  (pt_y),
        .pen   (pen_q),
        .sts   (f_sts)
    );

    assign m_axis_tdata = {{(mfd_pkg::OUT_TDATA_W-2){1'b0}}, out_inb, out_value};

endmodule

`default_nettype wire

/* rtl/core/mfd_checker.sv */
// Port-level checker for the draw engine, bound to the top level.
`default_nettype none

module mfd_checker (
    input wire logic                             clk,
    input wire logic                             rst_n,
    input wire logic                             s_axis_tvalid,
    input wire logic                             s_axis_tready,
    input wire logic                             m_axis_tvalid,
    input wire logic                             m_axis_tready,
    input wire logic [mfd_pkg::OUT_TDATA_W-1:0]  m_axis_tdata
);

    // Result held until taken
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result transaction dropped before acceptance");

    // A pixel value only comes with an on-screen read
    a_val_inb: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> !(m_axis_tdata[0] && !m_axis_tdata[1]))
        else $error("read_value set without read_in_bounds");

    a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tdata[mfd_pkg::OUT_TDATA_W-1:2] == '0))
        else $error("result padding not zero");

    // One command at a time
    a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("command accepted while previous still running");

    // Clearing pass follows reset
    a_rst_clear: assert property (@(posedge clk) disable iff (!rst_n)
        !$past(rst_n) |-> !s_axis_tready)
        else $error("ready during post-reset clearing pass");

endmodule

bind mono_framebuffer_draw_engine mfd_checker u_mfd_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire
